// File: design/polu_pkg.sv
// shared types and constants of the positional ordered list unit
package polu_pkg;

   localparam int ACTION_W        = 3;
   localparam int POSITION_W      = 7;
   localparam int DATA_W          = 32;
   localparam int COUNT_W         = 7;
   localparam int REQ_TDATA_W     = 40;
   localparam int RSP_TDATA_W     = 40;
   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT      = 3'd0,
      ACT_REMOVE_AT   = 3'd1,
      ACT_REMOVE_HEAD = 3'd2,
      ACT_CLEAR       = 3'd3,
      ACT_READ        = 3'd4
   } action_type;

   typedef struct packed {
      logic load_new;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

endpackage

// File: design/positional_ordered_list_unit.sv
// top level of the positional ordered list unit
//
// Holds an ordered list of up to CAPACITY signed words in a row of cells.
// Each request item on req_ carries an action (insert, remove at position,
// remove head, clear, read) in req_tuser and a 1-based position and a value
// in req_tdata. Every request gives exactly one response item on rsp_ with
// a success flag in rsp_tuser and the read value and entry count in
// rsp_tdata.
// An insert or remove shifts all cells behind the position by one place at
// once; a read selects the addressed cell. A request is therefore finished
// as it is accepted and its response is registered: one item per cycle is
// sustained while the receiver takes them. When the receiver stalls, the
// response register holds its item and req_tready drops until it is
// taken.
// Reset empties the list and the response register; cell contents are not
// cleared and are never read before being written.
module positional_ordered_list_unit #(
   parameter int CAPACITY    = polu_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = polu_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position[6:0], item_value[38:7], zero pad
   input  logic [polu_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action[2:0]
   input  logic [polu_pkg::ACTION_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_value[31:0], entry_count[38:32], zero pad
   output logic [polu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // ok[0]
   output logic                               rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > polu_pkg::POSITION_W) ? CNT_W : polu_pkg::POSITION_W) + 1;
   localparam int PAD_W = polu_pkg::RSP_TDATA_W - polu_pkg::DATA_W - polu_pkg::COUNT_W;

   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [polu_pkg::DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [polu_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                            accept;
   polu_pkg::action_type            action;
   logic [polu_pkg::POSITION_W-1:0] position;
   logic [polu_pkg::DATA_W-1:0]     item_value;
   logic [VALUE_WIDTH-1:0]          new_value;
   logic [CMP_W-1:0]                pos_ext, cnt_ext, ins_pos, idx;
   logic                            do_insert, do_remove, do_read, ok;

   logic [VALUE_WIDTH-1:0]          cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0]          read_or    [CAPACITY+1];
   logic [VALUE_WIDTH-1:0]          read_word;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign action     = polu_pkg::action_type'(req_tuser);
   assign position   = req_tdata[polu_pkg::POSITION_W-1:0];
   assign item_value = req_tdata[polu_pkg::POSITION_W +: polu_pkg::DATA_W];
   assign pos_ext    = CMP_W'(position);
   assign cnt_ext    = CMP_W'(cnt_ff);

   generate
      if (VALUE_WIDTH <= polu_pkg::DATA_W) begin : g_narrow
         assign new_value = item_value[VALUE_WIDTH-1:0];
         if (VALUE_WIDTH == polu_pkg::DATA_W) begin : g_same
            assign rsp_value_in = (do_read && ok) ? read_word : '0;
         end else begin : g_ext
            assign rsp_value_in = (do_read && ok) ?
               {{(polu_pkg::DATA_W-VALUE_WIDTH){read_word[VALUE_WIDTH-1]}}, read_word} : '0;
         end
      end else begin : g_wide
         assign new_value = {{(VALUE_WIDTH-polu_pkg::DATA_W){item_value[polu_pkg::DATA_W-1]}},
                             item_value};
         assign rsp_value_in = (do_read && ok) ? read_word[polu_pkg::DATA_W-1:0] : '0;
      end
   endgenerate

   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_read   = 1'b0;
      ok        = 1'b0;
      cnt_in    = cnt_ff;
      ins_pos   = pos_ext;
      idx       = pos_ext - CMP_W'(1);
      if (pos_ext == '0) begin
         ins_pos = CMP_W'(1);
      end
      if (ins_pos > cnt_ext + CMP_W'(1)) begin
         ins_pos = cnt_ext + CMP_W'(1);
      end
      unique case (action) inside
         polu_pkg::ACT_INSERT: begin
            idx = ins_pos - CMP_W'(1);
            if (cnt_ext != CMP_W'(CAPACITY)) begin
               do_insert = 1'b1;
               ok        = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end
         end
         polu_pkg::ACT_REMOVE_AT, polu_pkg::ACT_REMOVE_HEAD: begin
            if (action == polu_pkg::ACT_REMOVE_HEAD) begin
               idx = '0;
               if (cnt_ff != '0) begin
                  ok = 1'b1;
               end
            end else if (pos_ext != '0 && pos_ext <= cnt_ext) begin
               ok = 1'b1;
            end
            if (ok) begin
               do_remove = 1'b1;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         polu_pkg::ACT_CLEAR: begin
            ok     = 1'b1;
            cnt_in = '0;
         end
         polu_pkg::ACT_READ: begin
            do_read = 1'b1;
            if (pos_ext != '0 && pos_ext <= cnt_ext) begin
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign read_or[0] = '0;

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         polu_pkg::cell_ctrl_type ctrl;
         logic [VALUE_WIDTH-1:0]  left_value;
         logic [VALUE_WIDTH-1:0]  right_value;

         always_comb begin
            ctrl.load_new   = accept && do_insert && (idx == CMP_W'(i));
            ctrl.take_left  = accept && do_insert && (idx < CMP_W'(i));
            ctrl.take_right = accept && do_remove && (idx <= CMP_W'(i));
         end

         if (i == 0) begin : g_first
            assign left_value = new_value;
         end else begin : g_mid
            assign left_value = cell_value[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
         end else begin : g_inner
            assign right_value = cell_value[i+1];
         end

         polu_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i])
         );

         assign read_or[i+1] = read_or[i] |
            ((idx == CMP_W'(i)) ? cell_value[i] : '0);
      end
   endgenerate

   assign read_word    = read_or[CAPACITY];
   assign rsp_ok_in    = ok;
   assign rsp_count_in = polu_pkg::COUNT_W'(cnt_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_value_ff <= rsp_value_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_value_ff};

endmodule

// File: design/polu_cell.sv
// one list cell: holds an entry, loads a new value or takes a neighbor's entry
module polu_cell #(
   parameter int VALUE_WIDTH = polu_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  polu_pkg::cell_ctrl_type    ctrl,
   input  logic [VALUE_WIDTH-1:0]     new_value,
   input  logic [VALUE_WIDTH-1:0]     left_value,
   input  logic [VALUE_WIDTH-1:0]     right_value,
   output logic [VALUE_WIDTH-1:0]     value
);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load_new) begin
         value_in = new_value;
      end else if (ctrl.take_left) begin
         value_in = left_value;
      end else if (ctrl.take_right) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
